// File: sv/tmmd_pkg.sv
// shared types, constants and segment lookup for the min/max thermometer display
package tmmd_pkg;

    localparam int SampleWidth  = 10;
    localparam int TempWidth    = 7;
    localparam int SegWidth     = 7;
    localparam int DigitWidth   = 4;
    localparam int ScaleWidth   = 23;
    localparam int ScaleShift   = 24;
    localparam int ProductWidth = SampleWidth + ScaleWidth;
    localparam int RawTempWidth = ProductWidth - ScaleShift;

    // ceil(0.4887 * 2^24), exact floor for every 10-bit sample
    localparam logic [ScaleWidth-1:0] SCALE_RECIP = 23'd8199026;
    localparam logic [TempWidth-1:0]  TEMP_CAP    = 7'd99;
    localparam logic [TempWidth-1:0]  TEMP_FLOOR  = 7'd0;
    localparam int                    NumDigits   = 10;

    typedef enum logic [1:0] {
        VIEW_LIVE = 2'd0,
        VIEW_MAX  = 2'd1,
        VIEW_MIN  = 2'd2
    } view_t;

    typedef logic [SegWidth-1:0] seg_t;

    typedef struct packed {
        logic [SampleWidth-1:0] adc_sample;
        logic                   max_button_down;
        logic                   min_button_down;
    } tmmd_sample_t;

    typedef struct packed {
        logic [TempWidth-1:0] shown_value;
        logic [1:0]           view;
        seg_t                 tens_segments;
        seg_t                 units_segments;
    } tmmd_display_t;

    // bit0 is segment a
    function automatic seg_t seg_lookup(input logic [DigitWidth-1:0] digit);
        seg_t pattern;
        unique case (digit)
            4'd0:    pattern = 7'd63;
            4'd1:    pattern = 7'd6;
            4'd2:    pattern = 7'd91;
            4'd3:    pattern = 7'd79;
            4'd4:    pattern = 7'd102;
            4'd5:    pattern = 7'd109;
            4'd6:    pattern = 7'd125;
            4'd7:    pattern = 7'd7;
            4'd8:    pattern = 7'd127;
            4'd9:    pattern = 7'd111;
            default: pattern = '0;
        endcase
        return pattern;
    endfunction

endpackage

// File: sv/temperature_min_max_display.sv
// top level: sample scaling, min/max tracking, view buttons and segment output
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+-----------------------
//   sample    | sample_valid / sample_ready  | tmmd_sample_t  sample
//   display   | display_valid / display_ready| tmmd_display_t display
//
// one request per cycle sustained while the display takes each result
// the path is input register, one 10x23 constant multiply, compares, output register
// reset clears the view to live, maximum to 0 and minimum to 99
// a stalled display holds its result; the input register still takes one request
module temperature_min_max_display
    import tmmd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    output logic          sample_ready,
    input  tmmd_sample_t  sample,
    output logic          display_valid,
    input  logic          display_ready,
    output tmmd_display_t display
);

    logic                    stage_valid_reg;
    tmmd_sample_t            stage_reg;
    logic                    out_valid_reg;
    tmmd_display_t           out_reg;

    view_t                   view_reg;
    view_t                   view_next;
    logic [TempWidth-1:0]    highest_reg;
    logic [TempWidth-1:0]    highest_next;
    logic [TempWidth-1:0]    lowest_reg;
    logic [TempWidth-1:0]    lowest_next;
    logic                    max_press_reg;
    logic                    max_press_next;
    logic                    min_press_reg;
    logic                    min_press_next;

    logic                    advance;
    logic                    step;
    logic [ProductWidth-1:0] product;
    logic [RawTempWidth-1:0] raw_temp;
    logic [TempWidth-1:0]    live_temp;
    logic [TempWidth-1:0]    shown;
    view_t                   view_shown;
    logic                    max_release;
    logic                    min_release;
    seg_t                    tens_seg;
    seg_t                    units_seg;

    assign advance      = !out_valid_reg || display_ready;
    assign step         = stage_valid_reg && advance;
    assign sample_ready = !stage_valid_reg || advance;

    assign display_valid = out_valid_reg;
    assign display       = out_reg;

    // degrees = floor(sample * 0.4887)
    assign product   = ProductWidth'(stage_reg.adc_sample) * ProductWidth'(SCALE_RECIP);
    assign raw_temp  = product[ProductWidth-1:ScaleShift];
    assign live_temp = (raw_temp > RawTempWidth'(TEMP_CAP)) ? TEMP_CAP
                                                           : raw_temp[TempWidth-1:0];

    assign max_release = !stage_reg.max_button_down && max_press_reg;
    assign min_release = !stage_reg.min_button_down && min_press_reg;

    always_comb
    begin
        view_next      = view_reg;
        highest_next   = highest_reg;
        lowest_next    = lowest_reg;
        max_press_next = max_press_reg;
        min_press_next = min_press_reg;
        shown          = live_temp;
        view_shown     = VIEW_LIVE;
        unique case (view_reg)
            VIEW_MAX:
            begin
                shown          = highest_reg;
                view_shown     = VIEW_MAX;
                max_press_next = stage_reg.max_button_down;
                if (max_release)
                begin
                    view_next = VIEW_LIVE;
                end
            end
            VIEW_MIN:
            begin
                shown          = lowest_reg;
                view_shown     = VIEW_MIN;
                min_press_next = stage_reg.min_button_down;
                if (min_release)
                begin
                    view_next = VIEW_LIVE;
                end
            end
            default:
            begin
                if (live_temp > highest_reg)
                begin
                    highest_next = live_temp;
                end
                if (live_temp < lowest_reg)
                begin
                    lowest_next = live_temp;
                end
                max_press_next = stage_reg.max_button_down;
                if (max_release)
                begin
                    view_next = VIEW_MAX;
                end
                else
                begin
                    min_press_next = stage_reg.min_button_down;
                    view_next      = min_release ? VIEW_MIN : VIEW_LIVE;
                end
            end
        endcase
    end

    tmmd_seg_encode u_seg_encode (
        .value          (shown),
        .tens_segments  (tens_seg),
        .units_segments (units_seg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            view_reg        <= VIEW_LIVE;
            highest_reg     <= TEMP_FLOOR;
            lowest_reg      <= TEMP_CAP;
            max_press_reg   <= 1'b0;
            min_press_reg   <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                stage_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= stage_valid_reg;
            end
            if (step)
            begin
                view_reg      <= view_next;
                highest_reg   <= highest_next;
                lowest_reg    <= lowest_next;
                max_press_reg <= max_press_next;
                min_press_reg <= min_press_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            stage_reg <= sample;
        end
        if (step)
        begin
            out_reg.shown_value    <= shown;
            out_reg.view           <= view_shown;
            out_reg.tens_segments  <= tens_seg;
            out_reg.units_segments <= units_seg;
        end
    end

endmodule

// File: sv/tmmd_seg_encode.sv
// splits a two-digit value into tens and units and encodes both for seven segments
module tmmd_seg_encode
    import tmmd_pkg::*;
(
    input  logic [TempWidth-1:0] value,
    output seg_t                 tens_segments,
    output seg_t                 units_segments
);

    logic [DigitWidth-1:0] tens;
    logic [TempWidth-1:0]  tens_x10;
    logic [TempWidth-1:0]  units_wide;

    // tens digit by threshold compares
    always_comb
    begin
        tens = '0;
        for (int i = 1; i < NumDigits; i++)
        begin
            if (value >= TempWidth'(10 * i))
            begin
                tens = DigitWidth'(i);
            end
        end
    end

    assign tens_x10   = (TempWidth'(tens) << 3) + (TempWidth'(tens) << 1);
    assign units_wide = value - tens_x10;

    assign tens_segments  = seg_lookup(tens);
    assign units_segments = seg_lookup(units_wide[DigitWidth-1:0]);

endmodule

// File: sv/tmmd_checker.sv
// port-level checks for the min/max thermometer display, bound to the top level
module tmmd_checker
    import tmmd_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          sample_valid,
    input logic          sample_ready,
    input tmmd_sample_t  sample,
    input logic          display_valid,
    input logic          display_ready,
    input tmmd_display_t display
);

    // shown value stays in display range
    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        display_valid |-> display.shown_value <= TEMP_CAP)
        else $error("shown value above display range");

    // an accepted request has a result out once it has passed the input and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |-> ##2 display_valid)
        else $error("result missing two cycles after request");

    // empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !display_valid |-> sample_ready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        display_valid && !display_ready |=> display_valid && $stable(display))
        else $error("stalled result changed");

endmodule

bind temperature_min_max_display tmmd_checker u_tmmd_checker (.*);

// File: dv/temperature_min_max_display_tb.sv
// self-checking testbench for the min/max thermometer display: directed table then random requests
`timescale 1ns / 100ps

module temperature_min_max_display_tb;
    import tmmd_pkg::*;

    typedef struct {
        tmmd_sample_t  stim;
        bit            typed;
        tmmd_display_t want;
    } table_row_t;

    localparam int   RandomRequests = 1950;
    localparam int   LongHoldCycles = 400;
    localparam int   DrainCycles    = 8;
    localparam seg_t DIGIT_SEGS [10] = '{7'd63, 7'd6, 7'd91, 7'd79, 7'd102,
                                         7'd109, 7'd125, 7'd7, 7'd127, 7'd111};

    logic          clk;
    logic          rst_n;
    logic          sample_valid;
    logic          sample_ready;
    tmmd_sample_t  sample;
    logic          display_valid;
    logic          display_ready;
    tmmd_display_t display;

    view_t                view_state;
    logic [TempWidth-1:0] highest_deg;
    logic [TempWidth-1:0] lowest_deg;
    logic                 max_pressed;
    logic                 min_pressed;

    tmmd_display_t expected_displays [$];
    int            display_errors;
    int            burst_left;
    bit            hold_req;
    bit            hold_done;
    table_row_t    directed_rows [$];

    temperature_min_max_display dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .display_valid (display_valid),
        .display_ready (display_ready),
        .display       (display)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [TempWidth-1:0] degrees_of(input logic [SampleWidth-1:0] raw);
        int unsigned deg;
        deg = (int'(raw) * 4887) / 10000;
        if (deg > 99)
            deg = 99;
        return deg[TempWidth-1:0];
    endfunction

    function automatic tmmd_display_t make_display(input int shown, input view_t v);
        tmmd_display_t d;
        d.shown_value    = shown[TempWidth-1:0];
        d.view           = v;
        d.tens_segments  = DIGIT_SEGS[(shown / 10) % 10];
        d.units_segments = DIGIT_SEGS[shown % 10];
        return d;
    endfunction

    // advances the thermometer state by one request and returns what it shows
    function tmmd_display_t predict_display(input tmmd_sample_t s);
        logic [TempWidth-1:0] shown;
        view_t                cur;
        logic                 released;
        cur = view_state;
        if (cur == VIEW_MAX)
        begin
            shown       = highest_deg;
            released    = max_pressed & ~s.max_button_down;
            max_pressed = s.max_button_down;
            if (released)
                view_state = VIEW_LIVE;
        end
        else if (cur == VIEW_MIN)
        begin
            shown       = lowest_deg;
            released    = min_pressed & ~s.min_button_down;
            min_pressed = s.min_button_down;
            if (released)
                view_state = VIEW_LIVE;
        end
        else
        begin
            cur   = VIEW_LIVE;
            shown = degrees_of(s.adc_sample);
            if (shown > highest_deg)
                highest_deg = shown;
            if (shown < lowest_deg)
                lowest_deg = shown;
            // max button has priority; min flag kept when max is released
            released    = max_pressed & ~s.max_button_down;
            max_pressed = s.max_button_down;
            if (released)
                view_state = VIEW_MAX;
            else
            begin
                released    = min_pressed & ~s.min_button_down;
                min_pressed = s.min_button_down;
                view_state  = released ? VIEW_MIN : VIEW_LIVE;
            end
        end
        return make_display(int'(shown), cur);
    endfunction

    function automatic table_row_t row(input int adc, input bit mx, input bit mn,
                                       input bit typed, input int shown, input view_t v);
        table_row_t r;
        r.stim.adc_sample      = adc[SampleWidth-1:0];
        r.stim.max_button_down = mx;
        r.stim.min_button_down = mn;
        r.typed                = typed;
        r.want                 = make_display(shown, v);
        return r;
    endfunction

    task automatic send_sample(input tmmd_sample_t item, input bit typed,
                               input tmmd_display_t want);
        tmmd_display_t predicted;
        sample       <= item;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        predicted = predict_display(item);
        expected_displays.push_back(typed ? want : predicted);
    endtask

    // sender bursts with random gaps
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            display_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        tmmd_display_t exp_d;
        if (rst_n && display_valid && display_ready)
        begin
            if (expected_displays.size() == 0)
            begin
                $error("display result with no request outstanding: %h", display);
                display_errors++;
            end
            else
            begin
                exp_d = expected_displays.pop_front();
                compare_field("shown_value", exp_d.shown_value, display.shown_value);
                compare_field("view", exp_d.view, display.view);
                compare_field("tens_segments", exp_d.tens_segments, display.tens_segments);
                compare_field("units_segments", exp_d.units_segments, display.units_segments);
            end
        end
    end

    // receiver stall pattern, plus one long hold-off
    initial
    begin
        logic [15:0] stall_mask;
        int          tick;
        display_ready = 1'b0;
        stall_mask    = 16'hFFFF;
        tick          = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                display_ready <= 1'b0;
                repeat (LongHoldCycles) @(posedge clk);
            end
            else
            begin
                if (tick % 64 == 0)
                    stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                             : (16'($urandom) | 16'h0001);
                display_ready <= stall_mask[tick % 16];
                tick++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("temperature_min_max_display regression: fail");
        $finish;
    end

    initial
    begin
        tmmd_sample_t  item;
        tmmd_display_t none;
        bit            max_lvl;
        bit            min_lvl;
        int            pick;
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        none           = '0;
        display_errors = 0;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        burst_left     = 1;
        view_state     = VIEW_LIVE;
        highest_deg    = TEMP_FLOOR;
        lowest_deg     = TEMP_CAP;
        max_pressed    = 1'b0;
        min_pressed    = 1'b0;
        max_lvl        = 1'b0;
        min_lvl        = 1'b0;

        // after reset, extremes, saturation edge, both views and button priority
        directed_rows.push_back(row(0,    0, 0, 1, 0,  VIEW_LIVE));
        directed_rows.push_back(row(1023, 0, 0, 1, 99, VIEW_LIVE));
        directed_rows.push_back(row(205,  0, 0, 1, 99, VIEW_LIVE));
        directed_rows.push_back(row(204,  0, 0, 1, 99, VIEW_LIVE));
        directed_rows.push_back(row(202,  0, 0, 0, 0,  VIEW_LIVE));
        directed_rows.push_back(row(500,  1, 0, 0, 0,  VIEW_LIVE));
        directed_rows.push_back(row(300,  1, 1, 0, 0,  VIEW_LIVE));
        directed_rows.push_back(row(100,  0, 1, 0, 0,  VIEW_LIVE));
        directed_rows.push_back(row(0,    0, 0, 1, 99, VIEW_MAX));
        directed_rows.push_back(row(1023, 1, 0, 1, 99, VIEW_MAX));
        directed_rows.push_back(row(0,    0, 0, 1, 99, VIEW_MAX));
        directed_rows.push_back(row(600,  0, 0, 0, 0,  VIEW_LIVE));
        directed_rows.push_back(row(1023, 0, 1, 1, 0,  VIEW_MIN));
        directed_rows.push_back(row(0,    0, 0, 1, 0,  VIEW_MIN));
        directed_rows.push_back(row(37,   0, 0, 0, 0,  VIEW_LIVE));
        directed_rows.push_back(row(1,    0, 1, 0, 0,  VIEW_LIVE));
        directed_rows.push_back(row(512,  0, 0, 0, 0,  VIEW_LIVE));
        directed_rows.push_back(row(0,    1, 0, 1, 0,  VIEW_MIN));
        directed_rows.push_back(row(1023, 0, 0, 1, 0,  VIEW_MIN));
        directed_rows.push_back(row(0,    0, 1, 1, 0,  VIEW_MIN));
        directed_rows.push_back(row(1023, 1, 0, 1, 0,  VIEW_MIN));
        directed_rows.push_back(row(21,   0, 0, 0, 0,  VIEW_LIVE));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_sample(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
            pace_sender();
        end

        for (int n = 0; n < RandomRequests; n++)
        begin
            if (n == 500)
                hold_req = 1'b1;
            pick = $urandom_range(0, 3);
            case (pick)
                0: item.adc_sample = 10'($urandom_range(0, 1023));
                1: item.adc_sample = 10'($urandom_range(195, 215));
                2: item.adc_sample = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
                default: item.adc_sample = 10'($urandom);
            endcase
            if ($urandom_range(0, 15) == 0)
            begin
                max_lvl = $urandom_range(0, 1);
                min_lvl = $urandom_range(0, 1);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    max_lvl = ~max_lvl;
                if ($urandom_range(0, 3) == 0)
                    min_lvl = ~min_lvl;
            end
            item.max_button_down = max_lvl;
            item.min_button_down = min_lvl;
            send_sample(item, 1'b0, none);
            pace_sender();
        end
        sample_valid <= 1'b0;

        while (expected_displays.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (expected_displays.size() != 0)
        begin
            $error("%0d display results never arrived", expected_displays.size());
            display_errors++;
        end

        if (display_errors == 0)
            $display("temperature_min_max_display regression: pass");
        else
            $display("temperature_min_max_display regression: fail");
        $finish;
    end

endmodule

// File: temperature_min_max_display.f
sv/tmmd_pkg.sv
sv/tmmd_seg_encode.sv
sv/temperature_min_max_display.sv
sv/tmmd_checker.sv
dv/temperature_min_max_display_tb.sv
